@@ design/chained_hash_table_engine_macros.svh @@
// Assertion macros shared by the checker.
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHTE_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");
// Implication whose consequent is checked in the cycle after the premise.
`define CHTE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");
`endif

@@ design/chte_pkg.sv @@
package chte_pkg;
	localparam int Buckets = 256;
	localparam int PoolNodes = 1024;
	localparam int BW = $clog2(Buckets);
	localparam int NW = $clog2(PoolNodes);
	localparam int LW = $clog2(PoolNodes + 1);
	localparam logic [LW-1:0] NIL = LW'(PoolNodes);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [31:0] lookup_key;
		logic [31:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] found_value;
		logic [10:0] entry_count;
	} rsp_t;

	// One word of a node store access, read or written.
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
		logic [LW-1:0] link;
	} node_t;
endpackage

@@ design/chte_chan_if.sv @@
interface chte_req_if import chte_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface chte_rsp_if import chte_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/chte_node_ram.sv @@
// Pool node store: one write port, one registered read port.
module chte_node_ram import chte_pkg::*; (
	input logic clk,
	input logic we,
	input logic [NW-1:0] waddr,
	input node_t wdata,
	input logic [NW-1:0] raddr,
	output node_t rdata
);
	node_t mem [PoolNodes];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/chte_head_ram.sv @@
// Bucket head store with a valid bit per bucket so that reset empties it at once.
module chte_head_ram import chte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic we,
	input logic [BW-1:0] waddr,
	input node_t wdata,
	input logic [BW-1:0] raddr,
	output node_t rdata
);
	node_t mem [Buckets];
	logic [Buckets-1:0] valid_q;
	node_t rd_q;
	logic rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// An entry never written reads as an empty head.
	assign rdata = rvalid_q ? rd_q : node_t'{key: '0, value: '0, link: NIL};
endmodule

@@ design/chained_hash_table_engine.sv @@
// Chained hash table engine.
// Requests arrive on the req channel (insert, search, remove with key and
// value); each gives exactly one word on the rsp channel with status,
// found value and the number of entries held afterwards.
// The bucket is key bits [8:1]. A head store holds one entry per bucket; further
// entries live in a pool of 1024 nodes linked from the head.
// A small sequencer walks the chain one node at a time (S_NRD, S_NODE) through the single
// read port of the node store, with one shared key comparator.
// From acceptance a request passes S_HRD and S_HEAD before the result word in S_OUT;
// each chain node read adds S_NRD and S_NODE, and a node write (insert
// into a chain, or a node freed on remove) adds S_FREE. An insert that pops the free list
// reads that node's link first, through S_NRD and S_NODE, before S_FREE.
// One request is in flight at a time; req.ready is low from acceptance until the
// cycle after its response is taken.
// Reset empties every bucket at once through per-bucket valid bits and empties
// the pool; no clearing pass is needed.
// If the receiver stalls, the response holds in its register and no new
// request is taken until it leaves.
module chained_hash_table_engine import chte_pkg::*; (
	input logic clk,
	input logic arst_n,
	chte_req_if.sink req,
	chte_rsp_if.source rsp
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HRD = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_NRD = 3'd3;
	localparam logic [2:0] S_NODE = 3'd4;
	localparam logic [2:0] S_FREE = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q;
	req_t req_q;
	logic [BW-1:0] bkt;
	node_t head_q, hrd, nrd, prev_node_q;
	logic [LW-1:0] cur_q, prev_q, free_q, unused_q;
	logic [10:0] count_q;
	logic [1:0] status_q;
	logic [31:0] fval_q;
	logic [NW:0] steps_q;

	logic h_we, n_we;
	node_t h_wd, n_wd;
	logic [NW-1:0] n_wa, n_ra;
	logic key_eq;

	assign bkt = req_q.lookup_key[BW:1];

	chte_head_ram u_head (.clk, .arst_n, .we(h_we), .waddr(bkt), .wdata(h_wd),
		.raddr(bkt), .rdata(hrd));
	chte_node_ram u_node (.clk, .we(n_we), .waddr(n_wa), .wdata(n_wd),
		.raddr(n_ra), .rdata(nrd));

	// Shared comparator: head key in the head step, node key otherwise.
	assign key_eq = ((state_q == S_HEAD) ? hrd.key : nrd.key) == req_q.lookup_key;

	// Memory port control for each step.
	always_comb begin
		h_we = 1'b0;
		h_wd = hrd;
		n_we = 1'b0;
		n_wa = cur_q[NW-1:0];
		n_wd = nrd;
		n_ra = cur_q[NW-1:0];
		unique case (state_q)
			S_HEAD: begin
				n_ra = free_q[NW-1:0];
				unique case (req_q.req_type)
					REQ_INSERT: begin
						if (hrd.link == NIL && hrd.key == '0) begin
							h_we = 1'b1;
							h_wd = node_t'{key: req_q.lookup_key,
								value: req_q.entry_value, link: NIL};
						end
					end
					REQ_REMOVE: begin
						if (key_eq && hrd.link == NIL) begin
							h_we = 1'b1;
							h_wd = node_t'{key: '0, value: '0, link: NIL};
						end
					end
					default: ;
				endcase
			end
			S_NODE: begin
				if (req_q.req_type == REQ_REMOVE) begin
					if (status_q == ST_OK) begin
						// Head removed: the first node moves up into the head.
						h_we = 1'b1;
						h_wd = nrd;
					end else if (key_eq) begin
						if (prev_q == NIL) begin
							h_we = 1'b1;
							h_wd = head_q;
							h_wd.link = nrd.link;
						end else begin
							n_we = 1'b1;
							n_wa = prev_q[NW-1:0];
							n_wd = node_t'{key: prev_node_q.key,
								value: prev_node_q.value, link: nrd.link};
						end
					end
				end
			end
			S_FREE: begin
				n_we = 1'b1;
				n_wa = cur_q[NW-1:0];
				n_wd = node_t'{key: req_q.lookup_key, value: req_q.entry_value,
					link: head_q.link};
				if (req_q.req_type == REQ_INSERT) begin
					h_we = 1'b1;
					h_wd = head_q;
					h_wd.link = cur_q;
				end else begin
					n_wd.link = free_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data = rsp_t'{status: status_q, found_value: fval_q, entry_count: count_q};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q <= NIL;
			unused_q <= '0;
			count_q <= '0;
			status_q <= ST_MISS;
			fval_q <= '0;
			cur_q <= NIL;
			prev_q <= NIL;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_HRD;
					end
				end
				S_HRD: state_q <= S_HEAD;
				S_HEAD: begin
					status_q <= ST_MISS;
					fval_q <= '0;
					prev_q <= NIL;
					steps_q <= '0;
					cur_q <= hrd.link;
					state_q <= S_OUT;
					unique case (req_q.req_type)
						REQ_INSERT: begin
							if (hrd.link == NIL && hrd.key == '0) begin
								status_q <= ST_OK;
								count_q <= count_q + 11'd1;
							end else if (free_q != NIL) begin
								// Pop the free list; the next link is read now.
								cur_q <= free_q;
								state_q <= S_NRD;
							end else if (unused_q != NIL) begin
								cur_q <= unused_q;
								unused_q <= unused_q + 1'b1;
								state_q <= S_FREE;
							end else begin
								status_q <= ST_FULL;
							end
						end
						REQ_SEARCH: begin
							if (key_eq) begin
								status_q <= ST_OK;
								fval_q <= hrd.value;
							end else if (hrd.link != NIL) begin
								state_q <= S_NRD;
							end
						end
						REQ_REMOVE: begin
							if (key_eq) begin
								status_q <= ST_OK;
								if (count_q != '0) count_q <= count_q - 11'd1;
								if (hrd.link != NIL) state_q <= S_NRD;
							end else if (hrd.link != NIL) begin
								state_q <= S_NRD;
							end
						end
						default: ;
					endcase
				end
				S_NRD: state_q <= S_NODE;
				S_NODE: begin
					if (req_q.req_type == REQ_INSERT) begin
						free_q <= (nrd.link > NIL) ? NIL : nrd.link;
						state_q <= S_FREE;
					end else if (req_q.req_type == REQ_REMOVE && status_q == ST_OK) begin
						// Head removed: first node was copied up, now freed.
						state_q <= S_FREE;
					end else if (key_eq) begin
						status_q <= ST_OK;
						if (req_q.req_type == REQ_SEARCH) begin
							fval_q <= nrd.value;
							state_q <= S_OUT;
						end else begin
							if (count_q != '0) count_q <= count_q - 11'd1;
							state_q <= S_FREE;
						end
					end else if (nrd.link >= NIL
						|| steps_q == (NW + 1)'(PoolNodes - 1)) begin
						state_q <= S_OUT;
					end else begin
						prev_q <= cur_q;
						cur_q <= nrd.link;
						steps_q <= steps_q + 1'b1;
						state_q <= S_NRD;
					end
				end
				S_FREE: begin
					if (req_q.req_type == REQ_INSERT) begin
						status_q <= ST_OK;
						count_q <= count_q + 11'd1;
					end else begin
						free_q <= cur_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request, head and previous node capture.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			req_q <= req.data;
		end
		if (state_q == S_HEAD) begin
			head_q <= hrd;
		end
		if (state_q == S_NODE) begin
			prev_node_q <= nrd;
		end
	end
endmodule

@@ design/chte_checker.sv @@
`include "chained_hash_table_engine_macros.svh"
// Port-level checks of the engine.
module chte_checker import chte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_status,
	input logic [10:0] rsp_count
);
	`CHTE_ASSERT_IMP(a_one_at_a_time, clk, arst_n, rsp_valid, !req_ready)
	`CHTE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`CHTE_ASSERT_IMP(a_status_code, clk, arst_n, rsp_valid,
		rsp_status == ST_OK || rsp_status == ST_MISS || rsp_status == ST_FULL)
	`CHTE_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_count))
endmodule

bind chained_hash_table_engine chte_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
	.rsp_count(rsp.data.entry_count)
);

@@ tb/sv/chained_hash_table_engine_tb.sv @@
module chained_hash_table_engine_tb import chte_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Request code that the block does not know.
	localparam logic [1:0] ReqUnknown = 2'd3;

	logic clk;
	logic arst_n;
	chte_req_if req ();
	chte_rsp_if rsp ();

	chained_hash_table_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Stimulus row: a word to send and, where marked, the result typed in by hand.
	typedef struct {
		req_t word;
		bit fixed;
		rsp_t result;
	} row_t;

	// Shadow copy of the table contents.
	logic [31:0] head_keys [Buckets];
	logic [31:0] head_vals [Buckets];
	logic [LW-1:0] head_links [Buckets];
	logic [31:0] node_keys [PoolNodes];
	logic [31:0] node_vals [PoolNodes];
	logic [LW-1:0] node_links [PoolNodes];
	logic [LW-1:0] free_top;
	logic [LW-1:0] fresh_mark;
	logic [10:0] entries_held;

	rsp_t pending_results [$];
	logic [31:0] live_keys [$];
	row_t rows [$];
	int errors = 0;
	bit long_hold_req = 0;
	bit long_hold_done = 0;
	int hold_left = 0;
	int stall_left = 0;

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Generous limit on the whole run.
	initial begin
		#20ms;
		$display("chained_hash_table_engine_tb NOT OK");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Applies one request to the shadow table and returns the word it should give.
	function automatic rsp_t table_apply(input req_t r);
		logic [BW-1:0] b;
		logic [LW-1:0] first;
		logic [LW-1:0] cur;
		logic [LW-1:0] prev;
		logic [LW-1:0] n;
		bit hit;
		rsp_t o;
		b = r.lookup_key[BW:1];
		first = head_links[b];
		o.status = ST_MISS;
		o.found_value = '0;
		hit = 0;
		case (r.req_type)
			REQ_INSERT: begin
				if (first == NIL && head_keys[b] == 0) begin
					head_keys[b] = r.lookup_key;
					head_vals[b] = r.entry_value;
					entries_held++;
					o.status = ST_OK;
				end else begin
					// Free list first, then the never used part of the pool.
					if (free_top != NIL) begin
						n = free_top;
						free_top = node_links[n];
					end else if (fresh_mark != NIL) begin
						n = fresh_mark;
						fresh_mark++;
					end else begin
						n = NIL;
					end
					if (n == NIL) begin
						o.status = ST_FULL;
					end else begin
						node_keys[n] = r.lookup_key;
						node_vals[n] = r.entry_value;
						node_links[n] = first;
						head_links[b] = n;
						entries_held++;
						o.status = ST_OK;
					end
				end
			end
			REQ_SEARCH: begin
				if (head_keys[b] == r.lookup_key) begin
					o.status = ST_OK;
					o.found_value = head_vals[b];
				end else begin
					cur = first;
					while (cur != NIL && !hit) begin
						if (node_keys[cur] == r.lookup_key) begin
							hit = 1;
							o.status = ST_OK;
							o.found_value = node_vals[cur];
						end else begin
							cur = node_links[cur];
						end
					end
				end
			end
			REQ_REMOVE: begin
				if (head_keys[b] == r.lookup_key) begin
					// A head with a chain takes over the first node's entry.
					if (first == NIL) begin
						head_keys[b] = '0;
						head_vals[b] = '0;
					end else begin
						head_keys[b] = node_keys[first];
						head_vals[b] = node_vals[first];
						head_links[b] = node_links[first];
						node_links[first] = free_top;
						free_top = first;
					end
					o.status = ST_OK;
				end else begin
					prev = NIL;
					cur = first;
					while (cur != NIL && !hit) begin
						if (node_keys[cur] == r.lookup_key) begin
							hit = 1;
							if (prev == NIL)
								head_links[b] = node_links[cur];
							else
								node_links[prev] = node_links[cur];
							node_links[cur] = free_top;
							free_top = cur;
							o.status = ST_OK;
						end else begin
							prev = cur;
							cur = node_links[cur];
						end
					end
				end
				if (o.status == ST_OK && entries_held != 0)
					entries_held--;
			end
			default: ;
		endcase
		o.entry_count = entries_held;
		return o;
	endfunction

	// Keys gathered on a few buckets so that chains grow, with some wide ones.
	function automatic logic [31:0] pick_key();
		int r;
		logic [22:0] hi;
		int idx;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 20)
			return $urandom;
		if (r < 55 && live_keys.size() != 0) begin
			idx = $urandom_range(live_keys.size() - 1);
			return live_keys[idx];
		end
		case ($urandom_range(3))
			0: hi = '0;
			1: hi = 23'h7fffff;
			2: hi = 23'h2aaaaa;
			default: hi = 23'h555555;
		endcase
		return {hi, 8'($urandom_range(7) * 37), 1'($urandom)};
	endfunction

	function automatic req_t random_word(input int ins_pct);
		req_t w;
		int r;
		r = $urandom_range(99);
		w.entry_value = $urandom;
		w.lookup_key = pick_key();
		if (r < ins_pct)
			w.req_type = REQ_INSERT;
		else if (r < ins_pct + (100 - ins_pct) / 2)
			w.req_type = REQ_SEARCH;
		else if (r < 98)
			w.req_type = REQ_REMOVE;
		else
			w.req_type = ReqUnknown;
		return w;
	endfunction

	// Offers one word and records its expected result once it is taken.
	task automatic send(input row_t row);
		int gap;
		rsp_t want;
		int idx;
		gap = gap_len();
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= row.word;
		do
			@(posedge clk);
		while (!(req.valid && req.ready));
		want = table_apply(row.word);
		if (row.fixed)
			want = row.result;
		pending_results.push_back(want);
		if (row.word.req_type == REQ_INSERT && want.status == ST_OK) begin
			live_keys.push_back(row.word.lookup_key);
		end else if (row.word.req_type == REQ_REMOVE && want.status == ST_OK) begin
			for (idx = 0; idx < live_keys.size(); idx++) begin
				if (live_keys[idx] == row.word.lookup_key) begin
					live_keys.delete(idx);
					break;
				end
			end
		end
		@(negedge clk);
	endtask

	function automatic row_t mk(input logic [1:0] op, input logic [31:0] k,
			input logic [31:0] v, input bit fixed, input logic [1:0] st,
			input logic [31:0] fv, input logic [10:0] cnt);
		row_t r;
		r.word.req_type = op;
		r.word.lookup_key = k;
		r.word.entry_value = v;
		r.fixed = fixed;
		r.result.status = st;
		r.result.found_value = fv;
		r.result.entry_count = cnt;
		return r;
	endfunction

	// Receiver: random stalls, and one long hold-off while the sender keeps going.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			rsp.ready <= 1'b0;
			hold_left <= 400;
			long_hold_done <= 1'b1;
		end else if (stall_left != 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(7) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= gap_len();
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Every word taken from the block is compared with the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected word, status", rsp.data.status, '0);
			end else begin
				want = pending_results.pop_front();
				if (rsp.data.status !== want.status)
					report("status", rsp.data.status, want.status);
				if (rsp.data.found_value !== want.found_value)
					report("found_value", rsp.data.found_value, want.found_value);
				if (rsp.data.entry_count !== want.entry_count)
					report("entry_count", rsp.data.entry_count, want.entry_count);
			end
		end
	end

	// Main sequence: directed rows, mixed traffic, then a search and remove phase.
	initial begin
		int i;
		row_t r;
		int waited;
		for (i = 0; i < Buckets; i++) begin
			head_keys[i] = '0;
			head_vals[i] = '0;
			head_links[i] = NIL;
		end
		free_top = NIL;
		fresh_mark = '0;
		entries_held = '0;

		// Empty table, key zero on an empty head, count floor, unknown request.
		rows.push_back(mk(REQ_SEARCH, 32'd5, 32'd0, 1, ST_MISS, 32'd0, 11'd0));
		rows.push_back(mk(REQ_SEARCH, 32'd0, 32'hffffffff, 1, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_REMOVE, 32'd0, 32'd0, 1, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(ReqUnknown, 32'hffffffff, 32'hffffffff, 1, ST_MISS, 32'd0, 11'd0));
		rows.push_back(mk(REQ_INSERT, 32'd0, 32'hffffffff, 1, ST_OK, 32'd0, 11'd1));
		rows.push_back(mk(REQ_SEARCH, 32'd0, 32'd0, 1, ST_OK, 32'hffffffff, 11'd1));
		// A head still holding key zero is taken over by the next insert.
		rows.push_back(mk(REQ_INSERT, 32'd1, 32'h11, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_INSERT, 32'hffffffff, 32'd0, 1, ST_OK, 32'd0, 11'd3));
		rows.push_back(mk(REQ_INSERT, 32'h000001ff, 32'd5, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_INSERT, 32'hfffffe01, 32'h5a5a5a5a, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_SEARCH, 32'h000001ff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_SEARCH, 32'hffffffff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_REMOVE, 32'hffffffff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_SEARCH, 32'h000001ff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_REMOVE, 32'h000001ff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_SEARCH, 32'h000001ff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_INSERT, 32'h000003ff, 32'd1, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_INSERT, 32'h000005ff, 32'd2, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_INSERT, 32'h000007ff, 32'd3, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_REMOVE, 32'h000005ff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_SEARCH, 32'h000003ff, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(REQ_REMOVE, 32'h00000002, 32'd0, 0, ST_OK, 32'd0, 11'd0));
		rows.push_back(mk(ReqUnknown, 32'h12345678, 32'h9abcdef0, 0, ST_OK, 32'd0, 11'd0));

		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (rows[i])
			send(rows[i]);

		// Mixed traffic on crowded buckets, with the long hold-off part way in.
		for (i = 0; i < 630; i++) begin
			if (i == 150)
				long_hold_req = 1;
			r = mk(REQ_INSERT, 32'd0, 32'd0, 0, ST_OK, 32'd0, 11'd0);
			r.word = random_word(45);
			send(r);
		end

		// Mostly searches and removes, so that the table drains again.
		for (i = 0; i < 300; i++) begin
			r = mk(REQ_INSERT, 32'd0, 32'd0, 0, ST_OK, 32'd0, 11'd0);
			r.word = random_word(10);
			send(r);
		end
		req.valid <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("chained_hash_table_engine_tb OK");
		end else begin
			$display("chained_hash_table_engine_tb NOT OK");
		end
		$finish;
	end
endmodule
